/* rtl/core/apnt_pkg.sv */
// Shared widths, sideband types and register codes for the affine point/normal transform.
// No dependencies; used by every module under rtl/core.
package apnt_pkg;

    localparam int CW  = 16;  // coefficient, Q2.14
    localparam int VW  = 32;  // coordinate, Q16.16
    localparam int PW  = 48;  // coefficient times coordinate
    localparam int AW  = 50;  // row sum, Q.30
    localparam int MW  = 48;  // row sum magnitude
    localparam int NW  = 30;  // scaled magnitude
    localparam int SW  = 62;  // sum of squares
    localparam int LW  = 31;  // square root
    localparam int QW  = 17;  // normalized quotient
    localparam int DW  = 48;  // divider numerator
    localparam int XW  = 6;   // leading one position
    localparam int FB  = 16;  // fraction bits of the result
    localparam int NTOP = 29; // target leading one of the scaled maximum

    typedef logic [2:0][VW-1:0] t_vec3;
    typedef logic [2:0][NW-1:0] t_nmag3;

    typedef struct packed {
        logic       done;
        logic [2:0] neg;
        t_vec3      res;
    } t_side;

    typedef enum logic [2:0] {
        REG_ROW0,
        REG_ROW1,
        REG_ROW2,
        REG_TX,
        REG_TY,
        REG_TZ,
        REG_NEN
    } t_reg_idx;

endpackage

/* rtl/core/apnt_mac.sv */
// Matrix multiply stages: products, row sums, position finish and magnitudes.
// Depends on apnt_pkg.
module apnt_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_kind,
    input  apnt_pkg::t_vec3               i_vec,
    input  logic [2:0][apnt_pkg::MW-1:0]  i_row,
    input  apnt_pkg::t_vec3               i_trans,
    input  logic                          i_nen,
    output logic                          o_valid,
    output apnt_pkg::t_side               o_side,
    output logic [2:0][apnt_pkg::MW-1:0]  o_mag
);

    logic signed [apnt_pkg::PW-1:0] r_prod [3][3];
    logic signed [apnt_pkg::AW-1:0] r_acc  [3];
    apnt_pkg::t_vec3                r_vec1, r_vec2;
    logic                           r_kind1, r_kind2, r_pass1, r_pass2;
    logic                           r_v1, r_v2, r_v3;
    apnt_pkg::t_side                r_side3, n_side3;
    logic [2:0][apnt_pkg::MW-1:0]   r_mag3, n_mag3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= apnt_pkg::PW'($signed(i_row[r][16*c +: apnt_pkg::CW]))
                                  * apnt_pkg::PW'($signed(i_vec[c]));
                end
            end
            r_vec1  <= i_vec;
            r_kind1 <= i_kind;
            r_pass1 <= i_kind & ~i_nen;
            for (int r = 0; r < 3; r++) begin
                r_acc[r] <= apnt_pkg::AW'(r_prod[r][0]) + apnt_pkg::AW'(r_prod[r][1])
                          + apnt_pkg::AW'(r_prod[r][2]);
            end
            r_vec2  <= r_vec1;
            r_kind2 <= r_kind1;
            r_pass2 <= r_pass1;
            r_side3 <= n_side3;
            r_mag3  <= n_mag3;
        end
    end

    always_comb begin
        logic signed [51:0] s;
        logic               ovf;
        n_side3.done = ~r_kind2 | r_pass2;
        for (int r = 0; r < 3; r++) begin
            s = 52'(r_acc[r]) + {{6{i_trans[r][apnt_pkg::VW-1]}}, i_trans[r], 14'd0}
              + 52'sd8192;
            ovf = ~(&s[51:45] | ~|s[51:45]);
            n_side3.neg[r] = r_acc[r][apnt_pkg::AW-1];
            n_mag3[r] = r_acc[r][apnt_pkg::AW-1] ? apnt_pkg::MW'(-r_acc[r])
                                                 : apnt_pkg::MW'(r_acc[r]);
            if (r_pass2) begin
                n_side3.res[r] = r_vec2[r];
            end else if (ovf) begin
                n_side3.res[r] = s[51] ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
                n_side3.res[r] = s[45:14];
            end
        end
    end

    assign o_valid = r_v3;
    assign o_side  = r_side3;
    assign o_mag   = r_mag3;

endmodule

/* rtl/core/apnt_norm.sv */
// Normal scaling stages: maximum, leading one, power-of-two shift, squares, sum.
// Depends on apnt_pkg.
module apnt_norm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  apnt_pkg::t_side               i_side,
    input  logic [2:0][apnt_pkg::MW-1:0]  i_mag,
    output logic                          o_valid,
    output apnt_pkg::t_side               o_side,
    output apnt_pkg::t_nmag3              o_nmag,
    output logic [apnt_pkg::SW-1:0]       o_sumsq
);

    logic                           r_v4, r_v5, r_v6, r_v7, r_v8;
    apnt_pkg::t_side                r_side4, r_side5, r_side6, r_side7, r_side8;
    logic [2:0][apnt_pkg::MW-1:0]   r_mag4, r_mag5;
    logic [apnt_pkg::MW-1:0]        r_mx4, n_mx4;
    logic [apnt_pkg::XW-1:0]        r_msb5, n_msb5;
    logic                           r_zero5;
    apnt_pkg::t_nmag3               r_nm6, n_nm6, r_nm7, r_nm8;
    apnt_pkg::t_side                n_side6;
    logic [2:0][2*apnt_pkg::NW-1:0] r_sq7;
    logic [apnt_pkg::SW-1:0]        r_sum8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    always_comb begin
        n_mx4 = i_mag[0];
        if (i_mag[1] > n_mx4) n_mx4 = i_mag[1];
        if (i_mag[2] > n_mx4) n_mx4 = i_mag[2];
    end

    always_comb begin
        n_msb5 = '0;
        for (int i = 0; i < apnt_pkg::MW; i++) begin
            if (r_mx4[i]) n_msb5 = apnt_pkg::XW'(i);
        end
    end

    always_comb begin
        n_side6 = r_side5;
        for (int r = 0; r < 3; r++) begin
            if (r_msb5 >= apnt_pkg::XW'(apnt_pkg::NTOP)) begin
                n_nm6[r] = apnt_pkg::NW'(r_mag5[r] >> (r_msb5 - apnt_pkg::XW'(apnt_pkg::NTOP)));
            end else begin
                n_nm6[r] = apnt_pkg::NW'(r_mag5[r] << (apnt_pkg::XW'(apnt_pkg::NTOP) - r_msb5));
            end
        end
        if (r_zero5 && !r_side5.done) begin
            n_side6.done = 1'b1;
            n_side6.res  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side4 <= i_side;
            r_mag4  <= i_mag;
            r_mx4   <= n_mx4;
            r_side5 <= r_side4;
            r_mag5  <= r_mag4;
            r_msb5  <= n_msb5;
            r_zero5 <= (r_mx4 == '0);
            r_side6 <= n_side6;
            r_nm6   <= n_nm6;
            r_side7 <= r_side6;
            r_nm7   <= r_nm6;
            for (int r = 0; r < 3; r++) begin
                r_sq7[r] <= (2*apnt_pkg::NW)'(r_nm6[r]) * (2*apnt_pkg::NW)'(r_nm6[r]);
            end
            r_side8 <= r_side7;
            r_nm8   <= r_nm7;
            r_sum8  <= apnt_pkg::SW'(r_sq7[0]) + apnt_pkg::SW'(r_sq7[1])
                     + apnt_pkg::SW'(r_sq7[2]);
        end
    end

    assign o_valid = r_v8;
    assign o_side  = r_side8;
    assign o_nmag  = r_nm8;
    assign o_sumsq = r_sum8;

    a_scaled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v6 && !r_side6.done) |->
            (r_nm6[0][apnt_pkg::NTOP] || r_nm6[1][apnt_pkg::NTOP] || r_nm6[2][apnt_pkg::NTOP]))
        else $error("scaled maximum outside normalized range");

endmodule

/* rtl/core/apnt_sqrt.sv */
// Pipelined integer square root, one result bit per stage, sideband carried along.
// Depends on apnt_pkg.
module apnt_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  apnt_pkg::t_side          i_side,
    input  apnt_pkg::t_nmag3         i_nmag,
    input  logic [apnt_pkg::SW-1:0]  i_sumsq,
    output logic                     o_valid,
    output apnt_pkg::t_side          o_side,
    output apnt_pkg::t_nmag3         o_nmag,
    output logic [apnt_pkg::LW-1:0]  o_root
);

    localparam int NS = apnt_pkg::LW;

    logic                    w_v    [0:NS];
    apnt_pkg::t_side         w_side [0:NS];
    apnt_pkg::t_nmag3        w_nm   [0:NS];
    logic [apnt_pkg::SW-1:0] w_rem  [0:NS];
    logic [apnt_pkg::LW-1:0] w_root [0:NS];

    assign w_v[0]    = i_valid;
    assign w_side[0] = i_side;
    assign w_nm[0]   = i_nmag;
    assign w_rem[0]  = i_sumsq;
    assign w_root[0] = '0;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int B = NS - 1 - k;
        logic [63:0]             w_trial;
        logic                    w_ge;
        logic                    r_v;
        apnt_pkg::t_side         r_side;
        apnt_pkg::t_nmag3        r_nm;
        logic [apnt_pkg::SW-1:0] r_rem;
        logic [apnt_pkg::LW-1:0] r_root;

        assign w_trial = (64'(w_root[k]) << (B + 1)) + (64'd1 << (2 * B));
        assign w_ge    = 64'(w_rem[k]) >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side <= w_side[k];
                r_nm   <= w_nm[k];
                r_rem  <= w_ge ? apnt_pkg::SW'(64'(w_rem[k]) - w_trial) : w_rem[k];
                r_root <= w_ge ? (w_root[k] | (apnt_pkg::LW'(1) << B)) : w_root[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_side[k+1] = r_side;
        assign w_nm[k+1]   = r_nm;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
    end

    assign o_valid = w_v[NS];
    assign o_side  = w_side[NS];
    assign o_nmag  = w_nm[NS];
    assign o_root  = w_root[NS];

    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v[NS] && !w_side[NS].done) |->
            (w_root[NS][apnt_pkg::LW-1] || w_root[NS][apnt_pkg::LW-2]))
        else $error("vector length below scaled minimum");

endmodule

/* rtl/core/apnt_div.sv */
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on apnt_pkg.
module apnt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  apnt_pkg::t_side               i_side,
    input  apnt_pkg::t_nmag3              i_nmag,
    input  logic [apnt_pkg::LW-1:0]       i_root,
    output logic                          o_valid,
    output apnt_pkg::t_side               o_side,
    output logic [2:0][apnt_pkg::QW-1:0]  o_quot
);

    localparam int NS = apnt_pkg::QW;

    logic                           r_vp;
    apnt_pkg::t_side                r_sidep;
    logic [2:0][apnt_pkg::DW-1:0]   r_nump;
    logic [apnt_pkg::LW-1:0]        r_denp;

    logic                           w_v    [0:NS];
    apnt_pkg::t_side                w_side [0:NS];
    logic [2:0][apnt_pkg::DW-1:0]   w_num  [0:NS];
    logic [apnt_pkg::LW-1:0]        w_den  [0:NS];
    logic [2:0][apnt_pkg::QW-1:0]   w_q    [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (i_en) begin
            r_vp <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sidep <= i_side;
            r_denp  <= i_root;
            for (int r = 0; r < 3; r++) begin
                r_nump[r] <= (apnt_pkg::DW'(i_nmag[r]) << apnt_pkg::FB)
                           + apnt_pkg::DW'(i_root >> 1);
            end
        end
    end

    assign w_v[0]    = r_vp;
    assign w_side[0] = r_sidep;
    assign w_num[0]  = r_nump;
    assign w_den[0]  = r_denp;
    assign w_q[0]    = '0;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int B = NS - 1 - k;
        logic [apnt_pkg::DW-1:0]       w_dsh;
        logic                          r_v;
        apnt_pkg::t_side               r_side;
        logic [2:0][apnt_pkg::DW-1:0]  r_num;
        logic [apnt_pkg::LW-1:0]       r_den;
        logic [2:0][apnt_pkg::QW-1:0]  r_q;

        assign w_dsh = apnt_pkg::DW'(w_den[k]) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side <= w_side[k];
                r_den  <= w_den[k];
                for (int r = 0; r < 3; r++) begin
                    if (w_num[k][r] >= w_dsh) begin
                        r_num[r] <= w_num[k][r] - w_dsh;
                        r_q[r]   <= w_q[k][r] | (apnt_pkg::QW'(1) << B);
                    end else begin
                        r_num[r] <= w_num[k][r];
                        r_q[r]   <= w_q[k][r];
                    end
                end
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_side[k+1] = r_side;
        assign w_num[k+1]  = r_num;
        assign w_den[k+1]  = r_den;
        assign w_q[k+1]    = r_q;
    end

    assign o_valid = w_v[NS];
    assign o_side  = w_side[NS];
    assign o_quot  = w_q[NS];

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v[NS] && !w_side[NS].done) |->
            (w_q[NS][0] <= apnt_pkg::QW'(65536) && w_q[NS][1] <= apnt_pkg::QW'(65536)
             && w_q[NS][2] <= apnt_pkg::QW'(65536)))
        else $error("normalized component above one");

endmodule

/* rtl/core/affine_point_normal_transform_top.sv */
// Top level of the affine point/normal transform: register file, pipeline, output register.
// Depends on apnt_pkg, apnt_mac, apnt_norm, apnt_sqrt, apnt_div.
//
// Input channel i_valid/o_ready carries one vector (i_kind, i_in_x/y/z, Q16.16) per
// transaction; i_kind 0 is a position, 1 a normal. Output channel o_valid/i_ready returns
// one vector (o_out_x/y/z) per transaction, in input order.
// Positions get M*v + T with rounding and saturation; normals get M*v scaled to unit
// length (zero vector gives zero), or pass unchanged when normals_enable is 0.
// Every kind of item takes the same path: 3 multiply/sum stages, 5 scaling stages,
// 31 square root stages (one root bit each), 18 divider stages (17 quotient bits) and
// the output register. Throughput is one transaction per cycle when not stalled.
// All stages advance together; when the output register holds a result the receiver
// has not taken, the whole pipeline holds and o_ready drops, and nothing is lost.
// Reset clears the valid bits and loads identity M, zero T and normals_enable 1.
// Registers sit on the APB port at 8-byte steps; write them only while the pipeline
// is empty.
module affine_point_normal_transform_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [31:0] i_in_x,
    input  logic [31:0] i_in_y,
    input  logic [31:0] i_in_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [2:0][apnt_pkg::MW-1:0] r_row;
    apnt_pkg::t_vec3              r_trans;
    logic                         r_nen;
    apnt_pkg::t_reg_idx           w_idx;
    logic                         w_en;

    logic                         w_mac_v, w_norm_v, w_sqrt_v, w_div_v;
    apnt_pkg::t_side              w_mac_side, w_norm_side, w_sqrt_side, w_div_side;
    logic [2:0][apnt_pkg::MW-1:0] w_mag;
    apnt_pkg::t_nmag3             w_norm_nm, w_sqrt_nm;
    logic [apnt_pkg::SW-1:0]      w_sumsq;
    logic [apnt_pkg::LW-1:0]      w_root;
    logic [2:0][apnt_pkg::QW-1:0] w_quot;

    logic                         r_out_valid;
    apnt_pkg::t_vec3              r_out, n_out;

    assign w_idx  = apnt_pkg::t_reg_idx'(paddr[5:3]);
    assign pready = 1'b1;
    assign w_en   = ~r_out_valid | i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= {48'h4000_0000_0000, 48'h0000_4000_0000, 48'h0000_0000_4000};
            r_trans <= '0;
            r_nen   <= 1'b1;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                apnt_pkg::REG_ROW0: r_row[0]   <= pwdata[47:0];
                apnt_pkg::REG_ROW1: r_row[1]   <= pwdata[47:0];
                apnt_pkg::REG_ROW2: r_row[2]   <= pwdata[47:0];
                apnt_pkg::REG_TX:   r_trans[0] <= pwdata[31:0];
                apnt_pkg::REG_TY:   r_trans[1] <= pwdata[31:0];
                apnt_pkg::REG_TZ:   r_trans[2] <= pwdata[31:0];
                apnt_pkg::REG_NEN:  r_nen      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            apnt_pkg::REG_ROW0: prdata = {16'd0, r_row[0]};
            apnt_pkg::REG_ROW1: prdata = {16'd0, r_row[1]};
            apnt_pkg::REG_ROW2: prdata = {16'd0, r_row[2]};
            apnt_pkg::REG_TX:   prdata = {32'd0, r_trans[0]};
            apnt_pkg::REG_TY:   prdata = {32'd0, r_trans[1]};
            apnt_pkg::REG_TZ:   prdata = {32'd0, r_trans[2]};
            apnt_pkg::REG_NEN:  prdata = {63'd0, r_nen};
            default:            prdata = '0;
        endcase
    end

    apnt_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_vec   ({i_in_z, i_in_y, i_in_x}),
        .i_row   (r_row),
        .i_trans (r_trans),
        .i_nen   (r_nen),
        .o_valid (w_mac_v),
        .o_side  (w_mac_side),
        .o_mag   (w_mag)
    );

    apnt_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mac_v),
        .i_side  (w_mac_side),
        .i_mag   (w_mag),
        .o_valid (w_norm_v),
        .o_side  (w_norm_side),
        .o_nmag  (w_norm_nm),
        .o_sumsq (w_sumsq)
    );

    apnt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_norm_v),
        .i_side  (w_norm_side),
        .i_nmag  (w_norm_nm),
        .i_sumsq (w_sumsq),
        .o_valid (w_sqrt_v),
        .o_side  (w_sqrt_side),
        .o_nmag  (w_sqrt_nm),
        .o_root  (w_root)
    );

    apnt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sqrt_v),
        .i_side  (w_sqrt_side),
        .i_nmag  (w_sqrt_nm),
        .i_root  (w_root),
        .o_valid (w_div_v),
        .o_side  (w_div_side),
        .o_quot  (w_quot)
    );

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (w_div_side.done) begin
                n_out[r] = w_div_side.res[r];
            end else if (w_div_side.neg[r]) begin
                n_out[r] = -apnt_pkg::VW'(w_quot[r]);
            end else begin
                n_out[r] = apnt_pkg::VW'(w_quot[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out_x = r_out[0];
    assign o_out_y = r_out[1];
    assign o_out_z = r_out[2];

endmodule
